// File: design/qse_pkg.sv
// Package with shared constants, types and state codes of the quicksort engine.
`timescale 1ns / 1ps

package qse_pkg;

  localparam int unsigned DEPTH       = 32;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  // Smaller part is worked first, so the pending-range stack stays near log2(DEPTH)
  localparam int unsigned STACK_DEPTH = IDX_W + 2;
  localparam int unsigned STK_W       = $clog2(STACK_DEPTH);
  localparam int unsigned TOP_W       = $clog2(STACK_DEPTH + 1);

  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [TOP_W-1:0]              top_t;
  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  typedef struct packed {
    idx_t lo;
    idx_t hi;
  } range_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_POP,
    ST_RANGE,
    ST_PIVOT,
    ST_J_SCAN,
    ST_I_SCAN,
    ST_SWAP,
    ST_SPLIT,
    ST_OUT_LOAD,
    ST_OUT_HOLD
  } state_e;

endpackage

// File: design/quicksort_engine_core.sv
// Quicksort engine: loads a set, sorts it in a synchronous store, emits it in order.
`timescale 1ns / 1ps

//  channel  | signals                                          | direction
//  ---------+--------------------------------------------------+----------
//  input    | in_valid_i, in_stall_o, value_i, last_i          | in
//  output   | out_valid_o, out_stall_i, sorted_value_o,        | out
//           | final_res_o, dropped_o                           |
//  config   | cfg_we_i, cfg_wdata_i (descending)               | in
//
//  Loading accepts one input transaction per cycle; the one flagged last starts the sort.
//  Sorting runs on the single-port-read element store, scanning, swapping and splitting
//  one range at a time while further ranges wait on the stack.
//  Each result is read from the store, then registered for output, and held while stalled.
//  No input is taken from the close of a set until its final result is delivered.
//  Reset clears control state only; the element store needs no clearing pass.

module quicksort_engine_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [qse_pkg::VALUE_WIDTH-1:0] value_i,
  input  logic                                  last_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [qse_pkg::VALUE_WIDTH-1:0] sorted_value_o,
  output logic                                  final_res_o,
  output logic                                  dropped_o
);

  qse_pkg::state_e state_q, state_d;
  qse_pkg::cnt_t   count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            desc_q;
  qse_pkg::idx_t   lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d, q_q, q_d, k_q, k_d;
  qse_pkg::val_t   pivot_q, pivot_d, vi_q, vi_d, vj_q, vj_d;
  qse_pkg::val_t   out_val_q, out_val_d;
  logic            final_q, final_d;
  qse_pkg::top_t   top_q, top_d;

  // element store
  qse_pkg::val_t   mem [qse_pkg::DEPTH];
  qse_pkg::val_t   rdata_q;
  qse_pkg::idx_t   raddr;
  logic            mem_we;
  qse_pkg::idx_t   waddr;
  qse_pkg::val_t   wdata;

  // pending-range stack
  qse_pkg::range_t stk [qse_pkg::STACK_DEPTH];
  logic            stk_we;
  qse_pkg::range_t stk_wdata;
  qse_pkg::range_t stk_rdata_q;

  qse_pkg::idx_t   qa, left_len, right_len;

  // Order test: a goes before b in the selected direction
  function automatic logic goes_before(qse_pkg::val_t a, qse_pkg::val_t b, logic desc);
    goes_before = desc ? (a > b) : (a < b);
  endfunction

  // Split-point clamp and part lengths
  assign qa        = (q_q >= hi_q) ? hi_q - qse_pkg::idx_t'(1) : q_q;
  assign left_len  = qa - lo_q;
  assign right_len = hi_q - qa - qse_pkg::idx_t'(1);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
    end else if (cfg_we_i) begin
      desc_q <= cfg_wdata_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qse_pkg::ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
      top_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      top_q   <= top_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    i_q       <= i_d;
    j_q       <= j_d;
    q_q       <= q_d;
    k_q       <= k_d;
    pivot_q   <= pivot_d;
    vi_q      <= vi_d;
    vj_q      <= vj_d;
    out_val_q <= out_val_d;
    final_q   <= final_d;
  end

  // Element store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Range stack: push at the top, registered read of the top entry (ready by pop)
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk[qse_pkg::STK_W'(top_q)] <= stk_wdata;
    end
    stk_rdata_q <= stk[qse_pkg::STK_W'(top_q - qse_pkg::top_t'(1))];
  end

  // Next state and datapath control
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    top_d     = top_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    i_d       = i_q;
    j_d       = j_q;
    q_d       = q_q;
    k_d       = k_q;
    pivot_d   = pivot_q;
    vi_d      = vi_q;
    vj_d      = vj_q;
    out_val_d = out_val_q;
    final_d   = final_q;
    raddr     = '0;
    mem_we    = 1'b0;
    waddr     = '0;
    wdata     = value_i;
    stk_we    = 1'b0;
    stk_wdata = '{lo: lo_q, hi: hi_q};

    case (state_q)
      qse_pkg::ST_LOAD: begin
        // Store the element, or drop it when the store is full
        if (in_valid_i) begin
          if (count_q == qse_pkg::cnt_t'(qse_pkg::DEPTH)) begin
            ovf_d = 1'b1;
          end else begin
            mem_we  = 1'b1;
            waddr   = qse_pkg::idx_t'(count_q);
            count_d = count_q + qse_pkg::cnt_t'(1);
          end
          if (last_i) begin
            state_d = qse_pkg::ST_START;
          end
        end
      end

      qse_pkg::ST_START: begin
        top_d = '0;
        lo_d  = '0;
        hi_d  = qse_pkg::idx_t'(count_q - qse_pkg::cnt_t'(1));
        if (count_q < qse_pkg::cnt_t'(2)) begin
          k_d     = '0;
          raddr   = '0;
          state_d = qse_pkg::ST_OUT_LOAD;
        end else begin
          state_d = qse_pkg::ST_RANGE;
        end
      end

      qse_pkg::ST_POP: begin
        // Take the next pending range, or start output when none is left
        if (top_q == '0) begin
          k_d     = '0;
          raddr   = '0;
          state_d = qse_pkg::ST_OUT_LOAD;
        end else begin
          lo_d    = stk_rdata_q.lo;
          hi_d    = stk_rdata_q.hi;
          top_d   = top_q - qse_pkg::top_t'(1);
          state_d = qse_pkg::ST_RANGE;
        end
      end

      qse_pkg::ST_RANGE: begin
        if (lo_q < hi_q) begin
          i_d     = lo_q;
          j_d     = hi_q;
          raddr   = lo_q;
          state_d = qse_pkg::ST_PIVOT;
        end else begin
          state_d = qse_pkg::ST_POP;
        end
      end

      qse_pkg::ST_PIVOT: begin
        pivot_d = rdata_q;
        raddr   = j_q;
        state_d = qse_pkg::ST_J_SCAN;
      end

      qse_pkg::ST_J_SCAN: begin
        // Walk j down past elements that belong after the pivot
        if (j_q > lo_q && goes_before(pivot_q, rdata_q, desc_q)) begin
          j_d   = j_q - qse_pkg::idx_t'(1);
          raddr = j_q - qse_pkg::idx_t'(1);
        end else begin
          vj_d    = rdata_q;
          raddr   = i_q;
          state_d = qse_pkg::ST_I_SCAN;
        end
      end

      qse_pkg::ST_I_SCAN: begin
        // Walk i up past elements that belong before the pivot
        if (i_q < hi_q && goes_before(rdata_q, pivot_q, desc_q)) begin
          i_d   = i_q + qse_pkg::idx_t'(1);
          raddr = i_q + qse_pkg::idx_t'(1);
        end else if (i_q < j_q) begin
          mem_we  = 1'b1;
          waddr   = i_q;
          wdata   = vj_q;
          vi_d    = rdata_q;
          state_d = qse_pkg::ST_SWAP;
        end else begin
          q_d     = j_q;
          state_d = qse_pkg::ST_SPLIT;
        end
      end

      qse_pkg::ST_SWAP: begin
        // Finish the swap and narrow the window
        mem_we = 1'b1;
        waddr  = j_q;
        wdata  = vi_q;
        i_d    = i_q + qse_pkg::idx_t'(1);
        j_d    = j_q - qse_pkg::idx_t'(1);
        if ((qse_pkg::cnt_t'(i_q) + qse_pkg::cnt_t'(2)) <= qse_pkg::cnt_t'(j_q)) begin
          raddr   = j_q - qse_pkg::idx_t'(1);
          state_d = qse_pkg::ST_J_SCAN;
        end else begin
          q_d     = j_q - qse_pkg::idx_t'(1);
          state_d = qse_pkg::ST_SPLIT;
        end
      end

      qse_pkg::ST_SPLIT: begin
        // Push the larger part while the stack has a free slot, keep working on the smaller one
        if (top_q < qse_pkg::top_t'(qse_pkg::STACK_DEPTH)) begin
          stk_we = 1'b1;
          top_d  = top_q + qse_pkg::top_t'(1);
        end
        if (left_len < right_len) begin
          stk_wdata = '{lo: qa + qse_pkg::idx_t'(1), hi: hi_q};
          hi_d      = qa;
        end else begin
          stk_wdata = '{lo: lo_q, hi: qa};
          lo_d      = qa + qse_pkg::idx_t'(1);
        end
        state_d = qse_pkg::ST_RANGE;
      end

      qse_pkg::ST_OUT_LOAD: begin
        out_val_d = rdata_q;
        final_d   = ((qse_pkg::cnt_t'(k_q) + qse_pkg::cnt_t'(1)) == count_q);
        state_d   = qse_pkg::ST_OUT_HOLD;
      end

      qse_pkg::ST_OUT_HOLD: begin
        // Advance once the result transaction completes
        if (!out_stall_i) begin
          if (final_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = qse_pkg::ST_LOAD;
          end else begin
            k_d     = k_q + qse_pkg::idx_t'(1);
            raddr   = k_q + qse_pkg::idx_t'(1);
            state_d = qse_pkg::ST_OUT_LOAD;
          end
        end
      end

      default: begin
        state_d = qse_pkg::ST_LOAD;
      end
    endcase
  end

  assign in_stall_o     = (state_q != qse_pkg::ST_LOAD);
  assign out_valid_o    = (state_q == qse_pkg::ST_OUT_HOLD);
  assign sorted_value_o = out_val_q;
  assign final_res_o    = final_q;
  assign dropped_o      = ovf_q;

`ifndef ASSERT_OFF
  // After the final result of a set the block takes input again
  a_final_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && final_res_o |=> !in_stall_o)
    else $error("input not reopened after final result");

  // Stack never grows past its slots
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= qse_pkg::top_t'(qse_pkg::STACK_DEPTH))
    else $error("range stack overrun");

  // Scan index j stays inside the current range
  a_j_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == qse_pkg::ST_J_SCAN |-> (j_q >= lo_q && j_q <= hi_q))
    else $error("scan index j left the range");

  // Store fill never exceeds its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= qse_pkg::cnt_t'(qse_pkg::DEPTH))
    else $error("element count exceeds store depth");
`endif

endmodule
